// ===== sv/agct_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// agct_pkg
// Shared widths, constants and types for the gap-column trim core.
// ============================================================================
package agct_pkg;

    // Alignment size limits
    localparam int MAX_COLS = 4096;
    localparam int MAX_ROWS = 1024;

    // Field widths
    localparam int COL_W     = $clog2(MAX_COLS);     // column index
    localparam int ROW_W     = $clog2(MAX_ROWS);     // row index
    localparam int NCOL_W    = COL_W + 1;            // column count register
    localparam int NROW_W    = ROW_W + 1;            // row count register
    localparam int THR_W     = 9;                    // Q1.8 threshold, 256 = 1.0
    localparam int CNT_W     = 11;                   // gap counter
    localparam int RES_W     = 8;                    // residue byte
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = NCOL_W;               // widest register
    localparam int OUT_W     = 32;                   // residue + row + col, byte padded

    localparam logic [RES_W-1:0] GAP_CHAR  = 8'd45;  // '-'
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_THRESHOLD = 2'd2;

    // Pass selector carried in tuser
    localparam logic MODE_COUNT  = 1'b0;
    localparam logic MODE_FILTER = 1'b1;

    // Item held in the read stage while the counter memory answers
    typedef struct packed {
        logic             mode;
        logic [RES_W-1:0] residue;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             mode_chg;   // first item after a pass change
        logic             last_col;   // item closes a row
    } agct_item_t;

endpackage

// ===== sv/alignment_gap_column_trim_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// alignment_gap_column_trim_core
// Two-pass gap column trimmer: counts gaps per column on the first pass and
// streams only residues of kept columns on the second.
// ============================================================================
//
//  channel | direction | payload
//  --------+-----------+------------------------------------------------------
//  s_axis  | in        | tdata[7:0] residue, tuser[0] mode (0 count, 1 filter)
//  m_axis  | out       | tdata[7:0] out_residue, [17:8] out_row, [29:18] out_col
//  cfg     | in        | cfg_we, cfg_index, cfg_data (write only)
//
//  One transaction per cycle sustained unless the output stalls; results pass
//  the read-stage and output registers. The column counter memory is read at
//  accept, written back in the cycle after; a write forwards into the following read.
//  s_tready drops only while a filter item waits on a stalled output register.
//  Reset clears position counters, pass tracking and valids; counter memory
//  contents are meaningful only after a count pass has written row zero.
//
module alignment_gap_column_trim_core
    import agct_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [RES_W-1:0]     s_tdata,    // [7:0] residue
    input  logic                 s_tuser,    // [0] mode
    // output stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_W-1:0]     m_tdata     // [7:0] residue, [17:8] row, [29:18] col
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [NROW_W-1:0] num_rows_reg;
    logic [NCOL_W-1:0] num_cols_reg;
    logic [THR_W-1:0]  gap_thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= NROW_W'(1);
            num_cols_reg <= NCOL_W'(1);
            gap_thr_reg  <= THR_W'(256);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NUM_ROWS:      num_rows_reg <= cfg_data[NROW_W-1:0];
                REG_NUM_COLS:      num_cols_reg <= cfg_data[NCOL_W-1:0];
                REG_GAP_THRESHOLD: gap_thr_reg  <= cfg_data[THR_W-1:0];
                default:           ;
            endcase
        end
    end

    // Clamp counts into the supported range
    logic [NROW_W-1:0] eff_rows;
    logic [NCOL_W-1:0] eff_cols;

    always_comb
    begin
        if (num_rows_reg == '0)
            eff_rows = NROW_W'(1);
        else if (num_rows_reg > NROW_W'(MAX_ROWS))
            eff_rows = NROW_W'(MAX_ROWS);
        else
            eff_rows = num_rows_reg;

        if (num_cols_reg == '0)
            eff_cols = NCOL_W'(1);
        else if (num_cols_reg > NCOL_W'(MAX_COLS))
            eff_cols = NCOL_W'(MAX_COLS);
        else
            eff_cols = num_cols_reg;
    end

    // ------------------------------------------------------------------
    // Handshake control
    // ------------------------------------------------------------------
    logic       s1_valid_reg;
    agct_item_t s1_reg;
    logic       m_tvalid_reg;
    logic       out_free;
    logic       s1_free;
    logic       s1_fire;
    logic       s_accept;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s1_free  = !s1_valid_reg || (s1_reg.mode == MODE_COUNT) || out_free;
    assign s1_fire  = s1_valid_reg && s1_free;
    assign s_tready = s1_free;
    assign s_accept = s_tvalid && s1_free;

    // ------------------------------------------------------------------
    // Position tracking at accept
    // ------------------------------------------------------------------
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              last_mode_reg;
    logic              mode_chg;
    logic [COL_W-1:0]  col_base, col_cur;
    logic [ROW_W-1:0]  row_base, row_cur;
    logic [NCOL_W-1:0] col_inc;
    logic [NROW_W-1:0] row_inc;
    logic              last_col;

    always_comb
    begin
        mode_chg = (s_tuser != last_mode_reg);
        col_base = mode_chg ? '0 : col_reg;
        row_base = mode_chg ? '0 : row_reg;
        col_cur  = ({1'b0, col_base} >= eff_cols) ? '0 : col_base;
        row_cur  = ({1'b0, row_base} >= eff_rows) ? '0 : row_base;
        col_inc  = {1'b0, col_cur} + NCOL_W'(1);
        row_inc  = {1'b0, row_cur} + NROW_W'(1);
        last_col = (col_inc >= eff_cols);
        col_next = last_col ? '0 : col_inc[COL_W-1:0];
        if (!last_col)
            row_next = row_cur;
        else if (row_inc >= eff_rows)
            row_next = '0;
        else
            row_next = row_inc[ROW_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            last_mode_reg <= MODE_COUNT;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s_accept)
            begin
                col_reg       <= col_next;
                row_reg       <= row_next;
                last_mode_reg <= s_tuser;
            end
            if (s_accept)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;
        end
    end

    // Read-stage payload
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_reg.mode     <= s_tuser;
            s1_reg.residue  <= s_tdata;
            s1_reg.col      <= col_cur;
            s1_reg.row      <= row_cur;
            s1_reg.mode_chg <= mode_chg;
            s1_reg.last_col <= last_col;
        end
    end

    // ------------------------------------------------------------------
    // Gap counter memory: read at accept, write back from the read stage
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] gap_mem [MAX_COLS];
    logic [CNT_W-1:0] rd_data_reg;
    logic             wr_en;
    logic [CNT_W-1:0] cnt_new;

    assign wr_en = s1_fire && (s1_reg.mode == MODE_COUNT);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            gap_mem[s1_reg.col] <= cnt_new;
        if (s_accept)
            rd_data_reg <= gap_mem[col_cur];
    end

    // Last write, forwarded over a read that raced it
    logic             fwd_valid_reg;
    logic [COL_W-1:0] fwd_col_reg;
    logic [CNT_W-1:0] fwd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_valid_reg <= 1'b0;
        else if (wr_en)
            fwd_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fwd_col_reg  <= s1_reg.col;
            fwd_data_reg <= cnt_new;
        end
    end

    // ------------------------------------------------------------------
    // Count update and keep decision
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]       cnt_old;
    logic                   is_gap;
    logic [CNT_W:0]         cnt_sum;
    logic [CNT_W+7:0]       lhs;
    logic [THR_W+NROW_W-1:0] rhs;
    logic                   keep;
    logic                   emit;

    always_comb
    begin
        cnt_old = (fwd_valid_reg && (fwd_col_reg == s1_reg.col)) ? fwd_data_reg
                                                                : rd_data_reg;
        is_gap  = (s1_reg.residue == GAP_CHAR);
        cnt_sum = {1'b0, cnt_old} + (CNT_W+1)'(is_gap);
        if (s1_reg.row == '0)
            cnt_new = CNT_W'(is_gap);
        else if (cnt_sum > {1'b0, COUNT_MAX})
            cnt_new = COUNT_MAX;
        else
            cnt_new = cnt_sum[CNT_W-1:0];

        // drop when gaps*256 >= threshold*rows
        lhs  = {cnt_old, 8'd0};
        rhs  = (THR_W+NROW_W)'(gap_thr_reg) * (THR_W+NROW_W)'(eff_rows);
        keep = ((THR_W+NROW_W)'(lhs) < rhs);
        emit = (s1_reg.mode == MODE_FILTER) && keep;
    end

    // Trimmed column position
    logic [COL_W-1:0] kept_reg;
    logic [COL_W-1:0] kept_base;

    assign kept_base = s1_reg.mode_chg ? '0 : kept_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            kept_reg <= '0;
        else if (s1_fire)
            kept_reg <= s1_reg.last_col ? '0 : (kept_base + COL_W'(emit));
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic load_out;
    logic [OUT_W-1:0] m_tdata_reg;

    assign load_out = s1_fire && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (load_out)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            m_tdata_reg <= {(OUT_W-RES_W-ROW_W-COL_W)'(0), kept_base,
                            s1_reg.row, s1_reg.residue};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== sv/agct_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// agct_checker
// Port-level checks for the gap-column trim core, bound to the top level.
// ============================================================================
module agct_checker
    import agct_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             s_tuser,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    // Held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output transaction changed while stalled");

    // Input side only backs up behind a stalled output
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back-pressure");

    // A count-pass transaction never produces a result
    a_count_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == MODE_COUNT) |-> ##2 !$rose(m_tvalid))
        else $error("result raised by a count-pass transaction");

    // Padding above the column field is zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_W-1:RES_W+ROW_W+COL_W] == '0))
        else $error("nonzero padding in output data");

endmodule

bind alignment_gap_column_trim_core agct_checker u_agct_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
